// ===== design/key_event_repeat_filter_top_macros.svh =====
// Assertion helpers for the key event repeat filter.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef KEY_EVENT_REPEAT_FILTER_TOP_MACROS_SVH
`define KEY_EVENT_REPEAT_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define KERF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kerf: same-cycle check failed");
`define KERF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kerf: next-cycle check failed");
`else
`define KERF_ASSERT_SAME(label, ante, cons)
`define KERF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/kerf_pkg.sv =====
`default_nettype none

package kerf_pkg;

    localparam int NUM_KEYS_DEF = 256;
    localparam int KEY_W        = 8;
    localparam int TIME_W       = 64;
    localparam int DELAY_W      = 16;
    localparam int MASK_W       = 64;
    localparam int NUM_MASKS    = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd500;
    localparam logic [KEY_W-1:0]   EXT_LIMIT   = 8'h7F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_DELAY = 3'd0,
        REG_EXCL_MASK_0  = 3'd1,
        REG_EXCL_MASK_1  = 3'd2,
        REG_EXCL_MASK_2  = 3'd3,
        REG_EXCL_MASK_3  = 3'd4
    } cfg_reg_t;

    typedef logic [NUM_MASKS-1:0][MASK_W-1:0] excl_mask_t;

    // per-key memory entry
    typedef struct packed {
        logic              down;
        logic [TIME_W-1:0] stamp;
    } key_entry_t;

    localparam int ENTRY_W = $bits(key_entry_t);

    typedef struct packed {
        logic [KEY_W-1:0] vk;
        logic             excluded;
        logic             in_range;
    } key_lookup_t;

    localparam logic [KEY_W-1:0] VK_MAP [256] = '{
        8'h00,8'h1B,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'hBD,8'hBB,
        8'h08,8'h09,8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4F,8'h50,8'hDB,8'hDD,
        8'h0D,
        8'hA2,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'hBA,8'hDE,8'hC0,8'hA0,
        8'hDC,
        8'h5A,8'h58,8'h43,8'h56,8'h42,8'h4E,8'h4D,8'hBC,8'hBE,8'hBF,8'hA1,8'h6A,8'hA4,8'h20,
        8'h14,
        8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h13,8'h91,8'h24,8'h26,
        8'h21,
        8'h6D,8'h25,8'h0C,8'h27,8'h6B,8'h23,8'h28,8'h22,8'h2D,8'h2E,8'h2C,8'h00,8'hE2,8'h7A,
        8'h7B,
        8'h0C,8'hEE,8'hF1,8'hEA,8'hF9,8'hF5,8'hF3,8'h00,8'h00,8'hFB,8'h2F,8'h7C,8'h7D,8'h7E,
        8'h7F,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'hED,8'h00,8'hE9,8'h00,8'hC1,8'h00,8'h00,
        8'h87,
        8'h00,8'h00,8'h00,8'h00,8'hEB,8'h09,8'h00,8'hC2,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hB1,8'h00,8'h00,8'h00,
        8'h00,
        8'h00,8'h00,8'h00,8'h00,8'hB0,8'h00,8'h00,8'h0D,8'hA3,8'h00,8'h00,8'hAD,8'hB6,8'hB3,
        8'h00,
        8'hB2,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hAE,8'h00,8'hAF,8'h00,
        8'hB7,
        8'h00,8'h00,8'hBF,8'h00,8'h2A,8'hA5,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,
        8'h00,8'h00,8'h00,8'h90,8'h00,8'h24,8'h26,8'h21,8'h00,8'h25,8'h00,8'h27,8'h00,8'h23,
        8'h28,
        8'h22,8'h2D,8'h2E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h5B,8'h5C,8'h5D,8'h00,
        8'h5F,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'hAA,8'hAB,8'hA8,8'hA9,8'hA7,8'hA6,8'hAC,8'hB4,8'hB5,
        8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,
        8'h00,8'h00
    };

endpackage

`default_nettype wire

// ===== design/kerf_if.sv =====
`default_nettype none

interface kerf_sample_if import kerf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_index;
    logic              pressed_now;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, key_index, pressed_now, now_ms, input ready);
    modport sink   (input valid, key_index, pressed_now, now_ms, output ready);
endinterface

interface kerf_event_if import kerf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] virtual_code;
    logic             goes_down;
    logic [KEY_W-1:0] event_scancode;
    logic             extended_key;
    logic             was_pressed;

    modport source (output valid, virtual_code, goes_down, event_scancode, extended_key,
                    was_pressed, input ready);
    modport sink   (input valid, virtual_code, goes_down, event_scancode, extended_key,
                    was_pressed, output ready);
endinterface

interface kerf_cfg_if import kerf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/kerf_ram.sv =====
`default_nettype none

module kerf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/kerf_lookup.sv =====
`default_nettype none

module kerf_lookup import kerf_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic [KEY_W-1:0] key_index,
    input  wire excl_mask_t       excl_mask,
    output key_lookup_t           lookup
);

    logic [KEY_W-1:0] vk;

    always_comb
    begin
        vk              = VK_MAP[key_index];
        lookup.vk       = vk;
        lookup.excluded = excl_mask[vk[7:6]][vk[5:0]];
        lookup.in_range = ({1'b0, key_index} < (KEY_W+1)'(NUM_KEYS));
    end

endmodule

`default_nettype wire

// ===== design/key_event_repeat_filter_top.sv =====
// Channel  Dir  Payload
// cfg      in   index (3b), data (64b)
// sample   in   key_index, pressed_now, now_ms
// evt      out  virtual_code, goes_down, event_scancode, extended_key, was_pressed
//
// One sample per cycle while the sample side is not stalled. The accepting edge loads the stage registers
// and the key RAM read; an event from the compare result is then loaded into the output register.
// A write-back forwards into the next sample of the same key.
// Reset clears the per-key valid bits at once; no clearing pass.
// Only a pending event that finds the output register full while evt.ready is low stalls the sample side.
`default_nettype none
`include "key_event_repeat_filter_top_macros.svh"

module key_event_repeat_filter_top import kerf_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    kerf_cfg_if.sink    cfg,
    kerf_sample_if.sink sample,
    kerf_event_if.source evt
);

    localparam int KW = $clog2(NUM_KEYS);

    // configuration
    logic [DELAY_W-1:0] delay_reg;
    excl_mask_t         excl_mask_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= DELAY_RESET;
            excl_mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_REPEAT_DELAY: delay_reg        <= cfg.data[DELAY_W-1:0];
                REG_EXCL_MASK_0:  excl_mask_reg[0] <= cfg.data;
                REG_EXCL_MASK_1:  excl_mask_reg[1] <= cfg.data;
                REG_EXCL_MASK_2:  excl_mask_reg[2] <= cfg.data;
                REG_EXCL_MASK_3:  excl_mask_reg[3] <= cfg.data;
                default:          ;
            endcase
        end
    end

    // front stage
    key_lookup_t lookup;
    logic        accept;
    logic        s1_stall;

    kerf_lookup #(.NUM_KEYS(NUM_KEYS)) u_lookup (
        .key_index (sample.key_index),
        .excl_mask (excl_mask_reg),
        .lookup    (lookup)
    );

    assign sample.ready = !s1_stall;
    assign accept       = sample.valid && sample.ready;

    // key memory
    key_entry_t    ram_rdata;
    key_entry_t    wr_data;
    logic          wr_en;
    logic [KW-1:0] s1_addr;

    kerf_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_KEYS)) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (sample.key_index[KW-1:0]),
        .rd_data (ram_rdata)
    );

    // read-modify-write stage
    logic              s1_valid_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic              s1_down_reg;
    logic [TIME_W-1:0] s1_now_reg;
    key_lookup_t       s1_lookup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_stall)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg    <= sample.key_index;
            s1_down_reg   <= sample.pressed_now;
            s1_now_reg    <= sample.now_ms;
            s1_lookup_reg <= lookup;
        end
    end

    assign s1_addr = s1_key_reg[KW-1:0];

    logic [NUM_KEYS-1:0] key_valid_reg;
    logic                fwd_valid_reg;
    logic [KW-1:0]       fwd_addr_reg;
    key_entry_t          fwd_data_reg;

    key_entry_t        stored;
    logic              fwd_hit;
    logic [TIME_W-1:0] elapsed;
    logic              in_delay;
    logic              act;
    logic              emit;
    logic              out_valid_reg;

    always_comb
    begin
        // latest write to this key has not reached the RAM read yet
        fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr);
        if (fwd_hit)
        begin
            stored = fwd_data_reg;
        end
        else if (key_valid_reg[s1_addr])
        begin
            stored = ram_rdata;
        end
        else
        begin
            stored = '0;
        end
        elapsed  = s1_now_reg - stored.stamp;
        in_delay = elapsed < TIME_W'(delay_reg);
        act     = s1_valid_reg && s1_lookup_reg.in_range && (s1_down_reg || stored.down)
                  && !(s1_down_reg && stored.down && in_delay);
        emit    = act && !s1_lookup_reg.excluded;
        s1_stall = s1_valid_reg && emit && out_valid_reg && !evt.ready;
        wr_en   = act && !s1_stall;
        wr_data.down  = s1_down_reg;
        wr_data.stamp = stored.down ? '0 : s1_now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            key_valid_reg[s1_addr] <= 1'b1;
            fwd_valid_reg          <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // output register
    logic             out_valid_next;
    logic             out_load;
    logic [KEY_W-1:0] out_vk_reg;
    logic             out_down_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic             out_was_reg;

    assign out_load = emit && !s1_stall;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_vk_reg   <= s1_lookup_reg.vk;
            out_down_reg <= s1_down_reg;
            out_key_reg  <= s1_key_reg;
            out_was_reg  <= stored.down;
        end
    end

    assign evt.valid          = out_valid_reg;
    assign evt.virtual_code   = out_vk_reg;
    assign evt.goes_down      = out_down_reg;
    assign evt.event_scancode = out_key_reg;
    assign evt.extended_key   = (out_key_reg > EXT_LIMIT);
    assign evt.was_pressed    = out_was_reg;

    `KERF_ASSERT_SAME(a_no_write_on_stall, s1_stall, !wr_en)
    `KERF_ASSERT_SAME(a_no_write_out_of_range, s1_valid_reg && !s1_lookup_reg.in_range, !wr_en)
    `KERF_ASSERT_NEXT(a_write_marks_valid, wr_en, key_valid_reg[$past(s1_addr)] && fwd_valid_reg)

endmodule

`default_nettype wire

// ===== test/key_event_repeat_filter_top_test.sv =====
`timescale 1ns / 100ps

module key_event_repeat_filter_top_test import kerf_pkg::*; ;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int DRAIN_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam logic [DELAY_W-1:0]   HOLD_DELAY_AFTER_RESET = 16'd500;

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_PREDICT,
        ROW_QUIET,
        ROW_EVENT
    } row_kind_t;

    typedef struct packed {
        logic [KEY_W-1:0] vk;
        logic             goes_down;
        logic [KEY_W-1:0] scancode;
        logic             extended;
        logic             was_down;
    } key_event_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [KEY_W-1:0]      key;
        logic                  down;
        logic [TIME_W-1:0]     stamp;
        key_event_t            ev;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } step_row_t;

    localparam logic [KEY_W-1:0] SCAN_TO_VK [256] = '{
        'h00,'h1B,'h31,'h32,'h33,'h34,'h35,'h36,'h37,'h38,'h39,'h30,'hBD,'hBB,
        'h08,'h09,'h51,'h57,'h45,'h52,'h54,'h59,'h55,'h49,'h4F,'h50,'hDB,'hDD,'h0D,
        'hA2,'h41,'h53,'h44,'h46,'h47,'h48,'h4A,'h4B,'h4C,'hBA,'hDE,'hC0,'hA0,'hDC,
        'h5A,'h58,'h43,'h56,'h42,'h4E,'h4D,'hBC,'hBE,'hBF,'hA1,'h6A,'hA4,'h20,'h14,
        'h70,'h71,'h72,'h73,'h74,'h75,'h76,'h77,'h78,'h79,'h13,'h91,'h24,'h26,'h21,
        'h6D,'h25,'h0C,'h27,'h6B,'h23,'h28,'h22,'h2D,'h2E,'h2C,'h00,'hE2,'h7A,'h7B,
        'h0C,'hEE,'hF1,'hEA,'hF9,'hF5,'hF3,'h00,'h00,'hFB,'h2F,'h7C,'h7D,'h7E,'h7F,
        'h80,'h81,'h82,'h83,'h84,'h85,'h86,'hED,'h00,'hE9,'h00,'hC1,'h00,'h00,'h87,
        'h00,'h00,'h00,'h00,'hEB,'h09,'h00,'hC2,'h00,'h00,'h00,'h00,'h00,'h00,'h00,
        'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'hB1,'h00,'h00,'h00,'h00,
        'h00,'h00,'h00,'h00,'hB0,'h00,'h00,'h0D,'hA3,'h00,'h00,'hAD,'hB6,'hB3,'h00,
        'hB2,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'hAE,'h00,'hAF,'h00,'hB7,
        'h00,'h00,'hBF,'h00,'h2A,'hA5,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,
        'h00,'h00,'h00,'h90,'h00,'h24,'h26,'h21,'h00,'h25,'h00,'h27,'h00,'h23,'h28,
        'h22,'h2D,'h2E,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h5B,'h5C,'h5D,'h00,'h5F,
        'h00,'h00,'h00,'h00,'h00,'hAA,'hAB,'hA8,'hA9,'hA7,'hA6,'hAC,'hB4,'hB5,'h00,
        'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00,
        'h00,'h00
    };

    // kind, key, down, time, typed event, register index, register data
    localparam step_row_t DIRECTED [29] = '{
        '{ROW_EVENT,   8'h01, 1'b1, 64'd1000, '{8'h1B, 1'b1, 8'h01, 1'b0, 1'b0}, '0, '0},
        '{ROW_QUIET,   8'h01, 1'b1, 64'd1499, '0, '0, '0},
        '{ROW_EVENT,   8'h01, 1'b1, 64'd1500, '{8'h1B, 1'b1, 8'h01, 1'b0, 1'b1}, '0, '0},
        '{ROW_PREDICT, 8'h01, 1'b1, 64'd1501, '0, '0, '0},
        '{ROW_EVENT,   8'h01, 1'b0, 64'd1502, '{8'h1B, 1'b0, 8'h01, 1'b0, 1'b1}, '0, '0},
        '{ROW_QUIET,   8'h01, 1'b0, 64'd1503, '0, '0, '0},
        '{ROW_EVENT,   8'hFF, 1'b1, '1,       '{8'h00, 1'b1, 8'hFF, 1'b1, 1'b0}, '0, '0},
        '{ROW_QUIET,   8'hFF, 1'b1, 64'd0,    '0, '0, '0},
        '{ROW_PREDICT, 8'hFF, 1'b0, 64'h8000_0000_0000_0000, '0, '0, '0},
        '{ROW_PREDICT, 8'h80, 1'b1, 64'h5555_5555_5555_5555, '0, '0, '0},
        '{ROW_PREDICT, 8'h7F, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_EXCL_MASK_0, '1},
        '{ROW_QUIET,   8'h02, 1'b1, 64'd10,   '0, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_EXCL_MASK_0, '0},
        '{ROW_EVENT,   8'h02, 1'b0, 64'd20,   '{8'h31, 1'b0, 8'h02, 1'b0, 1'b1}, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_EXCL_MASK_3, '1},
        '{ROW_QUIET,   8'h1A, 1'b1, 64'd30,   '0, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_EXCL_MASK_3, '0},
        '{ROW_EVENT,   8'h1A, 1'b0, 64'd40,   '{8'hDB, 1'b0, 8'h1A, 1'b0, 1'b1}, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_REPEAT_DELAY, '0},
        '{ROW_EVENT,   8'h10, 1'b1, 64'd5,    '{8'h51, 1'b1, 8'h10, 1'b0, 1'b0}, '0, '0},
        '{ROW_EVENT,   8'h10, 1'b1, 64'd5,    '{8'h51, 1'b1, 8'h10, 1'b0, 1'b1}, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_REPEAT_DELAY, 64'hFFFF},
        '{ROW_EVENT,   8'h11, 1'b1, 64'd0,    '{8'h57, 1'b1, 8'h11, 1'b0, 1'b0}, '0, '0},
        '{ROW_QUIET,   8'h11, 1'b1, 64'hFFFE, '0, '0, '0},
        '{ROW_EVENT,   8'h11, 1'b1, 64'hFFFF, '{8'h57, 1'b1, 8'h11, 1'b0, 1'b1}, '0, '0},
        '{ROW_REG,     8'h00, 1'b0, 64'd0,    '0, REG_SPARE_LAST, '1},
        '{ROW_EVENT,   8'h11, 1'b0, 64'd1,    '{8'h57, 1'b0, 8'h11, 1'b0, 1'b1}, '0, '0},
        '{ROW_PREDICT, 8'h80, 1'b0, 64'd3,    '0, '0, '0}
    };

    logic clk;
    logic rst_n;

    kerf_cfg_if    reg_writes ();
    kerf_sample_if key_samples ();
    kerf_event_if  key_events ();

    key_event_repeat_filter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (reg_writes),
        .sample (key_samples),
        .evt    (key_events)
    );

    // filter state as the block should hold it
    logic               key_held    [256];
    logic [TIME_W-1:0]  press_stamp [256];
    logic [DELAY_W-1:0] hold_delay;
    logic [MASK_W-1:0]  vk_mask [NUM_MASKS];

    key_event_t  due_events [$];
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int unsigned cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("key_event_repeat_filter_top: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        key_events.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t %s: got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch_events
        key_event_t want;
        if (rst_n && key_events.valid && key_events.ready)
        begin
            if (due_events.size() == 0)
                report_mismatch("event with none due, scancode",
                                64'(key_events.event_scancode), '0);
            else
            begin
                want = due_events.pop_front();
                if (key_events.virtual_code !== want.vk)
                    report_mismatch("virtual_code", 64'(key_events.virtual_code),
                                    64'(want.vk));
                if (key_events.goes_down !== want.goes_down)
                    report_mismatch("goes_down", 64'(key_events.goes_down),
                                    64'(want.goes_down));
                if (key_events.event_scancode !== want.scancode)
                    report_mismatch("event_scancode", 64'(key_events.event_scancode),
                                    64'(want.scancode));
                if (key_events.extended_key !== want.extended)
                    report_mismatch("extended_key", 64'(key_events.extended_key),
                                    64'(want.extended));
                if (key_events.was_pressed !== want.was_down)
                    report_mismatch("was_pressed", 64'(key_events.was_pressed),
                                    64'(want.was_down));
            end
        end
    end

    function automatic logic filter_key_sample(input logic [KEY_W-1:0] key, input logic down,
                                               input logic [TIME_W-1:0] stamp,
                                               output key_event_t ev);
        logic             was;
        logic [KEY_W-1:0] vk;
        ev = '0;
        was = key_held[key];
        if (!down && !was)
            return 1'b0;
        // held key stays quiet until the delay has run out, wrapping difference
        if (down && was && (stamp - press_stamp[key]) < TIME_W'(hold_delay))
            return 1'b0;
        press_stamp[key] = was ? '0 : stamp;
        key_held[key] = down;
        vk = SCAN_TO_VK[key];
        // state moves on even when the event is masked
        if (vk_mask[vk[7:6]][vk[5:0]])
            return 1'b0;
        ev = '{vk, down, key, key > EXT_LIMIT, was};
        return 1'b1;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_REPEAT_DELAY: hold_delay = data[DELAY_W-1:0];
            REG_EXCL_MASK_0:  vk_mask[0] = data;
            REG_EXCL_MASK_1:  vk_mask[1] = data;
            REG_EXCL_MASK_2:  vk_mask[2] = data;
            REG_EXCL_MASK_3:  vk_mask[3] = data;
            default:          ;
        endcase
    endfunction

    // called at a falling edge; leaves at a falling edge with valid still up
    task automatic push_sample(input logic [KEY_W-1:0] key, input logic down,
                               input logic [TIME_W-1:0] stamp, input logic typed,
                               input logic typed_has, input key_event_t typed_ev);
        key_event_t ev;
        logic       has;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            key_samples.valid <= 1'b0;
            @(negedge clk);
        end
        key_samples.valid       <= 1'b1;
        key_samples.key_index   <= key;
        key_samples.pressed_now <= down;
        key_samples.now_ms      <= stamp;
        do
            @(posedge clk);
        while (!key_samples.ready);
        has = filter_key_sample(key, down, stamp, ev);
        if (typed)
        begin
            has = typed_has;
            ev = typed_ev;
        end
        if (has)
            due_events.push_back(ev);
        @(negedge clk);
    endtask

    // stop requests and let the pipeline run dry; quiet samples leave no trace
    task automatic settle();
        key_samples.valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_writes.valid <= 1'b1;
        reg_writes.index <= idx;
        reg_writes.data  <= data;
        do
            @(posedge clk);
        while (!reg_writes.ready);
        apply_register(idx, data);
        @(negedge clk);
    endtask

    initial
    begin
        step_row_t          row;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   pool [6];
        logic               down;
        logic [TIME_W-1:0]  stamp;
        logic [TIME_W-1:0]  clock_ms;
        logic [DELAY_W-1:0] delay_word;
        logic [MASK_W-1:0]  mask_word;
        int                 step_max;
        int                 pick;

        rst_n = 1'b0;
        key_samples.valid       = 1'b0;
        key_samples.key_index   = '0;
        key_samples.pressed_now = 1'b0;
        key_samples.now_ms      = '0;
        reg_writes.valid        = 1'b0;
        reg_writes.index        = '0;
        reg_writes.data         = '0;
        key_events.ready        = 1'b0;

        hold_delay = HOLD_DELAY_AFTER_RESET;
        for (int i = 0; i < 256; i++)
        begin
            key_held[i] = 1'b0;
            press_stamp[i] = '0;
        end
        for (int i = 0; i < NUM_MASKS; i++)
            vk_mask[i] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_REG)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
                reg_writes.valid <= 1'b0;
            end
            else
                push_sample(row.key, row.down, row.stamp, row.kind != ROW_PREDICT,
                            row.kind == ROW_EVENT, row.ev);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();

            if (phase < 2)
                pick = phase;
            else
                pick = $urandom_range(0, 3);
            case (pick)
                0:       delay_word = '0;
                1:       delay_word = '1;
                2:       delay_word = DELAY_W'($urandom_range(1, 40));
                default: delay_word = DELAY_W'($urandom_range(0, 65535));
            endcase
            write_reg(REG_REPEAT_DELAY, {$urandom, 16'($urandom_range(0, 65535)), delay_word});
            for (int m = 0; m < NUM_MASKS; m++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    mask_word = '0;
                else if (pick < 13)
                    mask_word = '1;
                else
                    mask_word = {$urandom, $urandom};
                write_reg(CFG_IDX_W'(REG_EXCL_MASK_0 + m), mask_word);
            end
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      {$urandom, $urandom});
            reg_writes.valid <= 1'b0;

            case (phase % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 48;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 48;
                end
                default:
                begin
                    src_idle_pct = 14;
                    sink_stall_pct = 14;
                end
            endcase

            // steps small against the delay so holds both wait and repeat
            step_max = (delay_word == 0) ? 64 : int'(delay_word) / 3 + 1;
            case ($urandom_range(0, 3))
                0:       clock_ms = TIME_W'($urandom_range(0, 1000));
                1:       clock_ms = '1 - TIME_W'($urandom_range(0, 200000));
                default: clock_ms = {$urandom, $urandom};
            endcase
            for (int p = 0; p < 6; p++)
                pool[p] = KEY_W'($urandom_range(0, 255));

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    key = KEY_W'($urandom_range(0, 255));
                    down = 1'($urandom_range(0, 1));
                    stamp = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : clock_ms;
                end
                else
                begin
                    key = pool[$urandom_range(0, 5)];
                    if (key_held[key])
                        down = ($urandom_range(0, 99) < 80);
                    else
                        down = ($urandom_range(0, 99) < 60);
                    stamp = clock_ms;
                end
                push_sample(key, down, stamp, 1'b0, 1'b0, '0);
                clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
                if (phase % 3 == 0 && n == ITEMS_PER_PHASE / 2)
                    settle();
            end
        end

        settle();
        if (mismatches == 0)
            $display("key_event_repeat_filter_top: match");
        else
            $display("key_event_repeat_filter_top: mismatch");
        $finish;
    end

endmodule
